// ===== rtl/tast_pkg.sv =====
// ----------------------------------------------------------------------------
// tast_pkg: shared types and constants of the thread address sharing tracker
// Item layouts, table sizes, action codes and the bucket hash.
// ----------------------------------------------------------------------------
package tast_pkg;

  localparam int unsigned Threads        = 64;
  localparam int unsigned AddrsPerThread = 128;
  localparam int unsigned Buckets        = 1024;

  localparam int unsigned SlotW   = $clog2(Threads);
  localparam int unsigned CountW  = $clog2(Threads + 1);
  localparam int unsigned AIdxW   = $clog2(AddrsPerThread);
  localparam int unsigned ACntW   = $clog2(AddrsPerThread + 1);
  localparam int unsigned BktW    = $clog2(Buckets);
  localparam int unsigned BCntW   = $clog2(Buckets + 1);
  localparam int unsigned AMemW   = SlotW + AIdxW;
  localparam int unsigned BMemW   = SlotW + BktW;

  localparam logic [63:0] HashMul = 64'd5;
  localparam logic [63:0] HashAdd = 64'd3;

  localparam logic ActRecord  = 1'b0;
  localparam logic ActCompare = 1'b1;

  typedef struct packed {
    logic        action;
    logic [21:0] thread_id;
    logic [63:0] address;
    logic [5:0]  slot_a;
    logic [5:0]  slot_b;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  thread_slot;
    logic        new_thread;
    logic        new_address;
    logic [15:0] address_hits;
    logic        dropped;
    logic [10:0] common_buckets;
    logic [10:0] set_bits_a;
    logic [10:0] set_bits_b;
    logic [7:0]  shared_weight_a;
    logic [7:0]  shared_weight_b;
    logic [7:0]  total_weight_a;
    logic [7:0]  total_weight_b;
  } out_item_t;

  // classified work passed from front to back
  typedef struct packed {
    logic             action;
    logic [63:0]      address;
    logic [SlotW-1:0] slot;
    logic             new_thread;
    logic             dropped;
    logic             va;
    logic             vb;
    logic [SlotW-1:0] slot_a;
    logic [SlotW-1:0] slot_b;
    logic [BktW-1:0]  bucket;
  } cmd_t;

endpackage

// ===== rtl/thread_address_sharing_tracker_core.sv =====
// ----------------------------------------------------------------------------
// thread_address_sharing_tracker_core: per-thread address sharing tracker
// Records samples into per-thread address lists and filters; compares two.
// ----------------------------------------------------------------------------
// After reset the bucket memory is swept clear before the first result can
// be formed; the front part may take one item meanwhile. A record compares
// thread ids and then addresses, each compare needing a table read state and
// a check state. A compare sweeps the buckets of two slots one bucket a
// cycle. The front part holds one classified item while the back part works.
module thread_address_sharing_tracker_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tast_pkg::in_item_t   in_item_i,
  input  logic                 push,
  output logic                 full,
  output tast_pkg::out_item_t  out_item_o,
  output logic                 empty,
  input  logic                 pop
);

  tast_pkg::cmd_t cmd;
  logic cmd_valid, cmd_ready;

  tast_front u_front (
    .clk_i, .rst_ni,
    .item_i(in_item_i), .push, .full,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready)
  );

  tast_back u_back (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .res_o(out_item_o), .empty, .pop
  );

endmodule

// ===== rtl/tast_front.sv =====
// ----------------------------------------------------------------------------
// tast_front: thread lookup and classification
// For records, finds or adds the thread by id with a scan over the thread
// table and hashes the address. Emits one command per item.
// ----------------------------------------------------------------------------
module tast_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tast_pkg::in_item_t  item_i,
  input  logic                push,
  output logic                full,
  output tast_pkg::cmd_t      cmd_o,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StChk  = 3'd2;
  localparam logic [2:0] StHash = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [21:0] tid_q [tast_pkg::Threads];
  logic [21:0] tid_rd_q;
  logic [tast_pkg::CountW-1:0] count_q, count_d;
  logic [tast_pkg::CountW-1:0] idx_q, idx_d;
  tast_pkg::in_item_t item_q;
  tast_pkg::cmd_t cmd_q, cmd_d;
  // only the low bucket bits of the hash product matter
  logic [tast_pkg::BktW-1:0] prod_q, prod_d;
  logic tid_we;
  logic [tast_pkg::SlotW-1:0] tid_wa;

  assign full        = (state_q != StIdle);
  assign cmd_o       = cmd_q;
  assign cmd_valid_o = (state_q == StOut);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    cmd_d   = cmd_q;
    prod_d  = prod_q;
    tid_we  = 1'b0;
    tid_wa  = count_q[tast_pkg::SlotW-1:0];
    case (state_q)
      StIdle: begin
        if (push) begin
          idx_d   = '0;
          cmd_d   = '0;
          cmd_d.action  = item_i.action;
          cmd_d.address = item_i.address;
          cmd_d.slot_a  = item_i.slot_a[tast_pkg::SlotW-1:0];
          cmd_d.slot_b  = item_i.slot_b[tast_pkg::SlotW-1:0];
          cmd_d.va = ({2'b0, item_i.slot_a} < 8'(tast_pkg::Threads)) &&
                     (8'(item_i.slot_a) < 8'(count_q));
          cmd_d.vb = ({2'b0, item_i.slot_b} < 8'(tast_pkg::Threads)) &&
                     (8'(item_i.slot_b) < 8'(count_q));
          state_d = (item_i.action == tast_pkg::ActCompare) ? StOut : StScan;
        end
      end
      StScan: begin
        // table read issued here; id compared next cycle
        if (idx_q == count_q) begin
          if (count_q == tast_pkg::CountW'(tast_pkg::Threads)) begin
            cmd_d.dropped = 1'b1;
            state_d = StOut;
          end else begin
            tid_we = 1'b1;
            cmd_d.slot = count_q[tast_pkg::SlotW-1:0];
            cmd_d.new_thread = 1'b1;
            count_d = count_q + 1'b1;
            prod_d  = item_q.address[tast_pkg::BktW-1:0] *
                      (item_q.address[tast_pkg::BktW-1:0] - 1'b1);
            state_d = StHash;
          end
        end else begin
          state_d = StChk;
        end
      end
      StChk: begin
        if (tid_rd_q == item_q.thread_id) begin
          cmd_d.slot = idx_q[tast_pkg::SlotW-1:0];
          prod_d  = item_q.address[tast_pkg::BktW-1:0] *
                    (item_q.address[tast_pkg::BktW-1:0] - 1'b1);
          state_d = StHash;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = StScan;
        end
      end
      StHash: begin
        cmd_d.bucket = tast_pkg::BktW'(prod_q * tast_pkg::HashMul + tast_pkg::HashAdd);
        state_d = StOut;
      end
      StOut: begin
        if (cmd_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    cmd_q  <= cmd_d;
    prod_q <= prod_d;
    if (state_q == StIdle && push) item_q <= item_i;
    if (tid_we) tid_q[tid_wa] <= item_q.thread_id;
    tid_rd_q <= tid_q[idx_q[tast_pkg::SlotW-1:0]];
  end

endmodule

// ===== rtl/tast_back.sv =====
// ----------------------------------------------------------------------------
// tast_back: address list update and filter intersection
// Records scan the thread's address list; compares sweep all buckets of two
// slots. A filter entry's count is zero exactly when its bit is clear, so the
// bucket memory holds counts only, cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module tast_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tast_pkg::cmd_t       cmd_i,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  output tast_pkg::out_item_t  res_o,
  output logic                 empty,
  input  logic                 pop
);

  localparam logic [2:0] StClr   = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StAScan = 3'd2;
  localparam logic [2:0] StAChk  = 3'd3;
  localparam logic [2:0] StBRd   = 3'd4;
  localparam logic [2:0] StBWr   = 3'd5;
  localparam logic [2:0] StCmp   = 3'd6;
  localparam logic [2:0] StOut   = 3'd7;

  // wide enough for the clearing sweep over the whole bucket memory
  localparam int unsigned ExtW = tast_pkg::BMemW;

  logic [2:0] state_q, state_d;
  tast_pkg::cmd_t cmd_q;
  tast_pkg::out_item_t res_q, res_d;

  logic [63:0] amem [tast_pkg::Threads*tast_pkg::AddrsPerThread];
  logic [15:0] hmem [tast_pkg::Threads*tast_pkg::AddrsPerThread];
  logic [7:0]  bmem_a [tast_pkg::Threads*tast_pkg::Buckets];
  logic [7:0]  bmem_b [tast_pkg::Threads*tast_pkg::Buckets];
  logic [tast_pkg::ACntW-1:0] acnt_q [tast_pkg::Threads];
  logic [tast_pkg::ACntW-1:0] acnt_rd_q;

  logic [tast_pkg::ACntW-1:0] ai_q, ai_d;
  logic [ExtW-1:0] k_q, k_d;
  logic [63:0] ard_q;
  logic [15:0] hrd_q;
  logic [7:0]  ca_q, cb_q;
  logic rd_v_q, rd_v_d;
  logic [11:0] sa_acc_q, sb_acc_q, com_q;
  logic [8:0]  swa_q, swb_q, twa_q, twb_q;
  logic [11:0] sa_acc_d, sb_acc_d, com_d;
  logic [8:0]  swa_d, swb_d, twa_d, twb_d;

  logic a_we, h_we, b_we, c_we;
  logic [tast_pkg::AMemW-1:0] a_addr;
  logic [tast_pkg::BMemW-1:0] b_addr, ba_addr, bb_addr;
  logic [15:0] h_wd;
  logic [7:0]  b_wd;
  logic [tast_pkg::ACntW-1:0] ac_wd;
  logic [tast_pkg::ACntW-1:0] n_cur;
  logic ba, bb;

  assign cmd_ready_o = (state_q == StIdle);
  assign empty       = (state_q != StOut);
  assign res_o       = res_q;
  assign n_cur       = cmd_q.new_thread ? '0 : acnt_rd_q;

  function automatic logic [8:0] sat8(input logic [8:0] v);
    return v[8] ? 9'd255 : v;
  endfunction

  always_comb begin
    state_d = state_q;
    res_d = res_q;
    ai_d = ai_q;
    k_d = k_q;
    rd_v_d = 1'b0;
    a_we = 1'b0; h_we = 1'b0; b_we = 1'b0; c_we = 1'b0;
    a_addr = {cmd_q.slot, ai_q[tast_pkg::AIdxW-1:0]};
    b_addr = {cmd_q.slot, cmd_q.bucket};
    h_wd = 16'd1;
    b_wd = 8'd0;
    ac_wd = n_cur + 1'b1;
    ba_addr = {cmd_q.slot_a, k_q[tast_pkg::BktW-1:0]};
    bb_addr = {cmd_q.slot_b, k_q[tast_pkg::BktW-1:0]};
    sa_acc_d = sa_acc_q; sb_acc_d = sb_acc_q; com_d = com_q;
    swa_d = swa_q; swb_d = swb_q; twa_d = twa_q; twb_d = twb_q;
    ba = cmd_q.va && (ca_q != 8'd0);
    bb = cmd_q.vb && (cb_q != 8'd0);
    case (state_q)
      StClr: begin
        b_we = 1'b1;
        b_addr = k_q[tast_pkg::BMemW-1:0];
        k_d = k_q + 1'b1;
        if (k_q == ExtW'(tast_pkg::Buckets*tast_pkg::Threads - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (cmd_valid_i) begin
          res_d = '0;
          ai_d = '0;
          k_d = '0;
          sa_acc_d = '0; sb_acc_d = '0; com_d = '0;
          swa_d = '0; swb_d = '0; twa_d = '0; twb_d = '0;
          if (cmd_i.action == tast_pkg::ActCompare) state_d = StCmp;
          else if (cmd_i.dropped) begin
            res_d.dropped = 1'b1;
            state_d = StOut;
          end else begin
            res_d.thread_slot = 6'(cmd_i.slot);
            res_d.new_thread = cmd_i.new_thread;
            state_d = StAScan;
          end
        end
      end
      StAScan: begin
        // memory read issued here; data compared next cycle
        if (ai_q == n_cur) begin
          if (n_cur == tast_pkg::ACntW'(tast_pkg::AddrsPerThread)) begin
            res_d.dropped = 1'b1;
            state_d = StOut;
          end else begin
            a_we = 1'b1; h_we = 1'b1; c_we = 1'b1;
            res_d.new_address = 1'b1;
            res_d.address_hits = 16'd1;
            state_d = StBRd;
          end
        end else begin
          state_d = StAChk;
        end
      end
      StAChk: begin
        if (ard_q == cmd_q.address) begin
          h_we = 1'b1;
          h_wd = (hrd_q == 16'hFFFF) ? hrd_q : hrd_q + 16'd1;
          res_d.address_hits = h_wd;
          state_d = StOut;
        end else begin
          ai_d = ai_q + 1'b1;
          state_d = StAScan;
        end
      end
      StBRd: state_d = StBWr;
      StBWr: begin
        b_we = 1'b1;
        b_wd = (ca_q == 8'hFF) ? ca_q : ca_q + 8'd1;
        state_d = StOut;
      end
      StCmp: begin
        // read of bucket k issued; accumulate previous read
        if (k_q < ExtW'(tast_pkg::Buckets)) k_d = k_q + 1'b1;
        rd_v_d = (k_q < ExtW'(tast_pkg::Buckets));
        if (rd_v_q) begin
          if (ba) begin
            sa_acc_d = sa_acc_q + 12'd1;
            twa_d = sat8(twa_q + 9'(ca_q));
          end
          if (bb) begin
            sb_acc_d = sb_acc_q + 12'd1;
            twb_d = sat8(twb_q + 9'(cb_q));
          end
          if (ba && bb) begin
            com_d = com_q + 12'd1;
            swa_d = sat8(swa_q + 9'(ca_q));
            swb_d = sat8(swb_q + 9'(cb_q));
          end
        end
        if (!rd_v_q && k_q == ExtW'(tast_pkg::Buckets)) begin
          res_d.common_buckets = 11'(com_q);
          res_d.set_bits_a = 11'(sa_acc_q);
          res_d.set_bits_b = 11'(sb_acc_q);
          res_d.shared_weight_a = swa_q[7:0];
          res_d.shared_weight_b = swb_q[7:0];
          res_d.total_weight_a = twa_q[7:0];
          res_d.total_weight_b = twb_q[7:0];
          state_d = StOut;
        end
      end
      StOut: begin
        if (pop) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr;
      k_q <= '0;
      rd_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q <= k_d;
      rd_v_q <= rd_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    ai_q <= ai_d;
    sa_acc_q <= sa_acc_d; sb_acc_q <= sb_acc_d; com_q <= com_d;
    swa_q <= swa_d; swb_q <= swb_d; twa_q <= twa_d; twb_q <= twb_d;
    if (state_q == StIdle && cmd_valid_i) begin
      cmd_q <= cmd_i;
      acnt_rd_q <= acnt_q[cmd_i.slot];
    end
    if (c_we) acnt_q[cmd_q.slot] <= ac_wd;
  end

  // address and hit memories
  always_ff @(posedge clk_i) begin
    if (a_we) amem[a_addr] <= cmd_q.address;
    ard_q <= amem[a_addr];
  end

  always_ff @(posedge clk_i) begin
    if (h_we) hmem[a_addr] <= h_wd;
    hrd_q <= hmem[a_addr];
  end

  // bucket counts: two copies, one read port each for the intersection sweep
  always_ff @(posedge clk_i) begin
    if (b_we) bmem_a[b_addr] <= b_wd;
    ca_q <= (state_q == StCmp) ? bmem_a[ba_addr] : bmem_a[b_addr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) bmem_b[b_addr] <= b_wd;
    cb_q <= bmem_b[bb_addr];
  end

endmodule

// ===== rtl/tast_checker.sv =====
// ----------------------------------------------------------------------------
// tast_checker: port-level checks of the tracker
// Watches input blocking and result consistency at the top level's ports.
// ----------------------------------------------------------------------------
module tast_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 push,
  input logic                 full,
  input tast_pkg::out_item_t  out_item_o,
  input logic                 empty,
  input logic                 pop
);

  a_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> full)
    else $error("accepted item did not block the input");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("result changed while waiting");

  a_newaddr_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.new_address) |-> (out_item_o.address_hits == 16'd1))
    else $error("new address without single hit");

  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.dropped) |-> (!out_item_o.new_address &&
      out_item_o.address_hits == 16'd0))
    else $error("dropped sample reports hits");

  a_common: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.common_buckets <= out_item_o.set_bits_a &&
      out_item_o.common_buckets <= out_item_o.set_bits_b))
    else $error("common buckets exceed set buckets");

endmodule

bind thread_address_sharing_tracker_core tast_checker u_tast_checker (
  .clk_i, .rst_ni, .push, .full, .out_item_o, .empty, .pop
);
